[src/bec_pkg.sv]
// Package: shared types, constants and byte mapping functions of the escape codec.
`default_nettype none
package bec_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0] CharNul       = 8'h00;
  localparam logic [ByteW-1:0] CharNewline   = 8'h0a;
  localparam logic [ByteW-1:0] CharComma     = 8'h2c;
  localparam logic [ByteW-1:0] CharBar       = 8'h7c;
  localparam logic [ByteW-1:0] CharBackslash = 8'h5c;
  localparam logic [ByteW-1:0] CharN         = 8'h6e;
  localparam logic [ByteW-1:0] CharC         = 8'h63;
  localparam logic [ByteW-1:0] CharZ         = 8'h7a;
  localparam logic [ByteW-1:0] CharY         = 8'h79;

  localparam logic [CountW-1:0] CapacityReset = 16'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIRECTION   = 2'd0,
    CFG_CAPACITY    = 2'd1,
    CFG_DOUBLE_BYTE = 2'd2
  } cfg_reg_e;

  // One queued request: one or two result bytes.
  typedef struct packed {
    logic             two;
    logic [ByteW-1:0] byte0;
    logic [ByteW-1:0] byte1;
    logic             eos;
    logic             trunc;
  } bec_entry_t;

  function automatic logic [ByteW-1:0] escape_code(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    case (b)
      CharNewline:   r = CharN;
      CharComma:     r = CharC;
      CharBar:       r = CharZ;
      CharBackslash: r = CharY;
      default:       r = CharNul;
    endcase
    return r;
  endfunction

  function automatic logic [ByteW-1:0] unescape_code(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    case (b)
      CharN:   r = CharNewline;
      CharC:   r = CharComma;
      CharZ:   r = CharBar;
      CharY:   r = CharBackslash;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[src/bec_if.sv]
// Interfaces: input byte, result and configuration channels of the escape codec.
`default_nettype none
interface bec_in_if import bec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface bec_out_if import bec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             last_of_run;
  logic             end_of_string;
  logic             truncated;
  modport source (output valid, output out_byte, output last_of_run,
                  output end_of_string, output truncated, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input end_of_string, input truncated, output ready);
endinterface

interface bec_cfg_if import bec_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[src/bec_front.sv]
// Front end: configuration registers, per-string state and byte classification.
`default_nettype none
module bec_front import bec_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  bec_in_if.sink          in_i,
  bec_cfg_if.sink         cfg_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output bec_entry_t      push_entry_o
);

  logic              direction_q;
  logic [CountW-1:0] capacity_q;
  logic              dbe_q;

  logic [CountW-1:0] written_q, written_d;
  logic              trail_q, trail_d;
  logic              esc_q, esc_d;
  logic              stopped_q, stopped_d;

  logic [ByteW-1:0]  b;
  logic [ByteW-1:0]  code;
  logic              lead;
  logic              accept;
  logic              trunc;
  logic              produce;
  logic [CountW:0]   w1;
  logic [CountW:0]   w2;
  logic [CountW:0]   cap;
  bec_entry_t        entry;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
      capacity_q  <= CapacityReset;
      dbe_q       <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_DIRECTION:   direction_q <= cfg_i.data[0];
        CFG_CAPACITY:    capacity_q  <= cfg_i.data[CountW-1:0];
        CFG_DOUBLE_BYTE: dbe_q       <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign b          = in_i.in_byte;
  assign lead       = dbe_q && b[ByteW-1];
  assign code       = escape_code(b);
  assign w1         = {1'b0, written_q} + {{CountW{1'b0}}, 1'b1};
  assign w2         = {1'b0, written_q} + {{(CountW-1){1'b0}}, 2'd2};
  assign cap        = {1'b0, capacity_q};

  always_comb begin
    written_d = written_q;
    trail_d   = trail_q;
    esc_d     = esc_q;
    stopped_d = stopped_q;
    produce   = 1'b0;
    trunc     = 1'b0;
    entry     = '{two: 1'b0, byte0: b, byte1: code, eos: 1'b0, trunc: 1'b0};
    if (stopped_q) begin
      if (b == CharNul) begin
        written_d = '0;
        trail_d   = 1'b0;
        esc_d     = 1'b0;
        stopped_d = 1'b0;
      end
    end else if (b == CharNul) begin
      produce   = 1'b1;
      entry.eos = 1'b1;
      written_d = '0;
      trail_d   = 1'b0;
      esc_d     = 1'b0;
    end else if (trail_q) begin
      produce = 1'b1;
      trail_d = 1'b0;
    end else if (direction_q) begin
      if (esc_q) begin
        esc_d       = 1'b0;
        produce     = 1'b1;
        entry.byte0 = unescape_code(b);
      end else if (lead) begin
        produce = 1'b1;
        trail_d = 1'b1;
      end else if (b == CharBackslash) begin
        esc_d = 1'b1;
      end else begin
        produce = 1'b1;
      end
    end else begin
      if (w1 >= cap) begin
        trunc = 1'b1;
      end else if (lead) begin
        if (w2 >= cap) begin
          trunc = 1'b1;
        end else begin
          produce   = 1'b1;
          written_d = w2[CountW-1:0];
          trail_d   = 1'b1;
        end
      end else if (code != CharNul) begin
        if (w2 < cap) begin
          produce     = 1'b1;
          entry.two   = 1'b1;
          entry.byte0 = CharBackslash;
          written_d   = w2[CountW-1:0];
        end else begin
          trunc = 1'b1;
        end
      end else begin
        produce   = 1'b1;
        written_d = w1[CountW-1:0];
      end
      if (trunc) begin
        produce     = 1'b1;
        entry.byte0 = CharNul;
        entry.eos   = 1'b1;
        entry.trunc = 1'b1;
        trail_d     = 1'b0;
        esc_d       = 1'b0;
        stopped_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      trail_q   <= 1'b0;
      esc_q     <= 1'b0;
      stopped_q <= 1'b0;
    end else if (accept) begin
      written_q <= written_d;
      trail_q   <= trail_d;
      esc_q     <= esc_d;
      stopped_q <= stopped_d;
    end
  end

  assign push_o       = accept && produce;
  assign push_entry_o = entry;

endmodule
`default_nettype wire

[src/bec_queue.sv]
// Request queue between the front end and the output stage.
`default_nettype none
module bec_queue import bec_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  bec_entry_t       push_entry_i,
  output logic             full_o,
  output logic             head_valid_o,
  output bec_entry_t       head_entry_o,
  input  wire logic        pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bec_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/bec_back.sv]
// Output stage: expands queued requests into result bytes behind an output register.
`default_nettype none
module bec_back import bec_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       head_valid_i,
  input  bec_entry_t      head_entry_i,
  output logic            pop_o,
  bec_out_if.source       out_o
);

  logic             valid_q;
  logic             phase_q;
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  logic             eos_q;
  logic             trunc_q;
  logic             load;

  assign load  = head_valid_i && (!valid_q || out_o.ready);
  assign pop_o = load && (phase_q || !head_entry_i.two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        phase_q <= !phase_q && head_entry_i.two;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= phase_q ? head_entry_i.byte1 : head_entry_i.byte0;
      last_q  <= phase_q || !head_entry_i.two;
      eos_q   <= head_entry_i.eos;
      trunc_q <= head_entry_i.trunc;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.out_byte      = byte_q;
  assign out_o.last_of_run   = last_q;
  assign out_o.end_of_string = eos_q;
  assign out_o.truncated     = trunc_q;

endmodule
`default_nettype wire

[src/backslash_escape_codec.sv]
// Top level: backslash escape encoder and decoder with double-byte pass-through.
//
//   channel  modport  handshake      payload
//   in_i     sink     valid/ready    in_byte
//   out_o    source   valid/ready    out_byte, last_of_run, end_of_string, truncated
//   cfg_i    sink     valid/ready    index, data (ready always high)
//
// One input byte is taken per cycle while the request queue has room.
// An escape pair leaves the output register one byte at a time, so the output
// register sets the rate at one result per cycle while out_o.ready is high.
// Reset clears string state, queue and output register; config takes its reset values.
// An output stall fills the queue, which then drops in_i.ready.
`default_nettype none
module backslash_escape_codec import bec_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bec_in_if.sink    in_i,
  bec_out_if.source out_o,
  bec_cfg_if.sink   cfg_i
);

  logic       q_full;
  logic       push;
  bec_entry_t push_entry;
  logic       head_valid;
  bec_entry_t head_entry;
  logic       pop;

  bec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  bec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry),
    .pop_i        (pop)
  );

  bec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire
